>>> hw/rtl/flow_pinned_wan_balancer_defines.svh
// Assertion macros for the flow-pinned WAN balancer.
// Depends on nothing; included by the top level only.
`ifndef FLOW_PINNED_WAN_BALANCER_DEFINES_SVH
`define FLOW_PINNED_WAN_BALANCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPWB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPWB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fpwb_pkg.sv
// Shared types and constants of the flow-pinned WAN balancer.
// Depends on nothing; used by every module of the block.
package fpwb_pkg;

    localparam int BUCKETS     = 1024;
    localparam int WAYS        = 4;
    localparam int MAX_UPLINKS = 4;
    localparam int BUCKET_W    = $clog2(BUCKETS);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int UPLINK_W    = 2;
    localparam int CNT_W       = 3;

    localparam logic [31:0] MIX_MUL_A = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_MUL_B = 32'hc2b2_ae35;
    localparam logic [7:0]  PROTO_TCP = 8'd6;

    localparam logic [2:0] REG_UPLINK_COUNT = 3'd0;
    localparam logic [2:0] REG_WINDOW_0     = 3'd1;
    localparam logic [2:0] REG_WINDOW_1     = 3'd2;
    localparam logic [2:0] REG_WINDOW_2     = 3'd3;
    localparam logic [2:0] REG_WINDOW_3     = 3'd4;
    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd5;

    typedef enum logic [1:0] {
        OP_PACKET    = 2'd0,
        OP_ADD_BYTES = 2'd1,
        OP_TICK      = 2'd2,
        OP_SWEEP     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_EVAL,
        ST_SWEEP_RD,
        ST_SWEEP_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [31:0]         low_ip;
        logic [31:0]         high_ip;
        logic [7:0]          proto;
        logic [31:0]         bytes;
        logic [UPLINK_W-1:0] uplink;
        logic [31:0]         seen;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic load;
        logic hash1;
        logic hash2;
        logic hash3;
        logic eval_commit;
        logic sweep_rd;
        logic sweep_wr;
        logic clear_wr;
        logic finish_commit;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

>>> hw/rtl/fpwb_ctrl.sv
// Controller state machine of the flow-pinned WAN balancer.
// Depends on fpwb_pkg; drives the datapath through command and status structs.
module fpwb_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  fpwb_pkg::sts_t sts,
    output fpwb_pkg::cmd_t cmd
);

    fpwb_pkg::state_t state_reg;
    fpwb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpwb_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            fpwb_pkg::ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.idx_last) begin
                    state_next = fpwb_pkg::ST_IDLE;
                end
            end
            fpwb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (sts.in_op)
                        fpwb_pkg::OP_TICK:  state_next = fpwb_pkg::ST_FINISH;
                        fpwb_pkg::OP_SWEEP: state_next = fpwb_pkg::ST_SWEEP_RD;
                        default:            state_next = fpwb_pkg::ST_HASH1;
                    endcase
                end
            end
            fpwb_pkg::ST_HASH1: begin
                cmd.hash1  = 1'b1;
                state_next = fpwb_pkg::ST_HASH2;
            end
            fpwb_pkg::ST_HASH2: begin
                cmd.hash2  = 1'b1;
                state_next = fpwb_pkg::ST_HASH3;
            end
            fpwb_pkg::ST_HASH3: begin
                cmd.hash3  = 1'b1;
                state_next = fpwb_pkg::ST_EVAL;
            end
            fpwb_pkg::ST_EVAL: begin
                if (sts.out_free) begin
                    cmd.eval_commit = 1'b1;
                    state_next      = fpwb_pkg::ST_IDLE;
                end
            end
            fpwb_pkg::ST_SWEEP_RD: begin
                cmd.sweep_rd = 1'b1;
                state_next   = fpwb_pkg::ST_SWEEP_WR;
            end
            fpwb_pkg::ST_SWEEP_WR: begin
                cmd.sweep_wr = 1'b1;
                state_next   = sts.idx_last ? fpwb_pkg::ST_FINISH : fpwb_pkg::ST_SWEEP_RD;
            end
            fpwb_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish_commit = 1'b1;
                    state_next        = fpwb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fpwb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/fpwb_dp.sv
// Datapath of the flow-pinned WAN balancer: registers, hash, flow table and result.
// Depends on fpwb_pkg; steered by fpwb_ctrl through command and status structs.
module fpwb_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fpwb_pkg::cmd_t                cmd,
    output fpwb_pkg::sts_t                sts,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic [1:0]                    s_operation,
    input  logic [31:0]                   s_first_ip,
    input  logic [31:0]                   s_second_ip,
    input  logic [7:0]                    s_proto_num,
    input  logic [31:0]                   s_byte_len,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fpwb_pkg::UPLINK_W-1:0] m_uplink,
    output logic                          m_found,
    output logic                          m_created,
    output logic                          m_bucket_full
);

    logic [fpwb_pkg::CNT_W-1:0] uplink_count_reg;
    logic [31:0]                window_reg [fpwb_pkg::MAX_UPLINKS];
    logic [15:0]                timeout_reg;

    fpwb_pkg::op_t op_reg;
    logic [31:0]   a_reg, b_reg, len_reg;
    logic [7:0]    proto_reg;
    logic [31:0]   lo_reg, hi_reg, p1_reg, p2_reg;
    logic [fpwb_pkg::BUCKET_W-1:0] bucket_reg, idx_reg;

    logic [31:0] rr_reg, now_reg;
    logic [1:0]  rr_mod3_reg;

    fpwb_pkg::row_t mem [fpwb_pkg::BUCKETS];
    fpwb_pkg::row_t rd_row_reg;

    logic                          m_valid_reg;
    logic [fpwb_pkg::UPLINK_W-1:0] m_uplink_reg;
    logic                          m_found_reg, m_created_reg, m_full_reg;

    logic [31:0] swap_a, swap_b, mix0, mix1, hash;
    logic [fpwb_pkg::BUCKET_W-1:0] bucket;
    logic [fpwb_pkg::CNT_W-1:0]    live_cnt;

    logic [fpwb_pkg::WAYS-1:0]  match_w, free_w;
    logic [fpwb_pkg::WAY_W-1:0] hit_idx, free_idx;
    logic                       hit, has_free;
    fpwb_pkg::way_t             hw;
    logic [31:0]                new_bytes, lim;
    logic [fpwb_pkg::CNT_W-1:0] cur_ext;
    logic                       move;
    logic [fpwb_pkg::UPLINK_W-1:0] next_up, hit_up, pick;
    fpwb_pkg::row_t             eval_row, sweep_row, wr_row;
    logic                       eval_created, eval_full;
    logic [fpwb_pkg::UPLINK_W-1:0] eval_up;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uplink_count_reg <= 3'd1;
            for (int i = 0; i < fpwb_pkg::MAX_UPLINKS; i++) begin
                window_reg[i] <= '0;
            end
            timeout_reg <= 16'd300;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fpwb_pkg::REG_UPLINK_COUNT: uplink_count_reg <= cfg_wdata[2:0];
                fpwb_pkg::REG_WINDOW_0:     window_reg[0] <= cfg_wdata;
                fpwb_pkg::REG_WINDOW_1:     window_reg[1] <= cfg_wdata;
                fpwb_pkg::REG_WINDOW_2:     window_reg[2] <= cfg_wdata;
                fpwb_pkg::REG_WINDOW_3:     window_reg[3] <= cfg_wdata;
                fpwb_pkg::REG_IDLE_TIMEOUT: timeout_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign swap_a = {a_reg[7:0], a_reg[15:8], a_reg[23:16], a_reg[31:24]};
    assign swap_b = {b_reg[7:0], b_reg[15:8], b_reg[23:16], b_reg[31:24]};
    assign mix0   = (a_reg ^ b_reg) ^ ((a_reg ^ b_reg) >> 16);
    assign mix1   = p1_reg ^ (p1_reg >> 13);
    assign hash   = p2_reg ^ (p2_reg >> 16);
    assign bucket = hash[fpwb_pkg::BUCKET_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= fpwb_pkg::op_t'(s_operation);
            a_reg     <= s_first_ip;
            b_reg     <= s_second_ip;
            proto_reg <= s_proto_num;
            len_reg   <= s_byte_len;
        end
        if (cmd.hash1) begin
            lo_reg <= (swap_a > swap_b) ? b_reg : a_reg;
            hi_reg <= (swap_a > swap_b) ? a_reg : b_reg;
            p1_reg <= mix0 * fpwb_pkg::MIX_MUL_A;
        end
        if (cmd.hash2) begin
            p2_reg <= mix1 * fpwb_pkg::MIX_MUL_B;
        end
        if (cmd.hash3) begin
            bucket_reg <= bucket;
        end
    end

    assign live_cnt = (uplink_count_reg > 3'(fpwb_pkg::MAX_UPLINKS))
                      ? 3'(fpwb_pkg::MAX_UPLINKS) : uplink_count_reg;

    always_comb begin
        match_w = '0;
        free_w  = '0;
        for (int w = 0; w < fpwb_pkg::WAYS; w++) begin
            match_w[w] = rd_row_reg[w].valid && rd_row_reg[w].low_ip == lo_reg
                         && rd_row_reg[w].high_ip == hi_reg;
            free_w[w]  = !rd_row_reg[w].valid;
        end
        hit_idx  = '0;
        free_idx = '0;
        for (int w = fpwb_pkg::WAYS - 1; w >= 0; w--) begin
            if (match_w[w]) begin
                hit_idx = fpwb_pkg::WAY_W'(w);
            end
            if (free_w[w]) begin
                free_idx = fpwb_pkg::WAY_W'(w);
            end
        end
    end

    assign hit       = |match_w;
    assign has_free  = |free_w;
    assign hw        = rd_row_reg[hit_idx];
    assign new_bytes = hw.bytes + len_reg;
    assign cur_ext   = {1'b0, hw.uplink};
    assign lim       = (cur_ext < live_cnt) ? window_reg[hw.uplink] : '0;
    assign move      = (hw.proto != fpwb_pkg::PROTO_TCP) && (lim != '0) && (new_bytes >= lim);
    assign next_up   = (cur_ext + 3'd1 == live_cnt) ? '0 : hw.uplink + 2'd1;
    assign hit_up    = move ? next_up : hw.uplink;

    always_comb begin
        case (live_cnt)
            3'd2:    pick = {1'b0, rr_reg[0]};
            3'd3:    pick = rr_mod3_reg;
            3'd4:    pick = rr_reg[1:0];
            default: pick = '0;
        endcase
    end

    always_comb begin
        eval_row     = rd_row_reg;
        eval_created = 1'b0;
        eval_full    = 1'b0;
        eval_up      = '0;
        if (op_reg == fpwb_pkg::OP_PACKET) begin
            if (hit) begin
                eval_row[hit_idx].seen   = now_reg;
                eval_row[hit_idx].bytes  = move ? '0 : new_bytes;
                eval_row[hit_idx].uplink = hit_up;
                eval_up                  = hit_up;
            end else if (has_free) begin
                eval_row[free_idx] = '{valid: 1'b1, low_ip: lo_reg, high_ip: hi_reg,
                                       proto: proto_reg, bytes: len_reg, uplink: pick,
                                       seen: now_reg};
                eval_created       = 1'b1;
                eval_up            = pick;
            end else begin
                eval_full = 1'b1;
            end
        end else if (hit) begin
            eval_row[hit_idx].bytes = new_bytes;
        end
    end

    always_comb begin
        sweep_row = rd_row_reg;
        for (int w = 0; w < fpwb_pkg::WAYS; w++) begin
            if ((now_reg - rd_row_reg[w].seen) > {16'd0, timeout_reg}) begin
                sweep_row[w].valid = 1'b0;
            end
        end
    end

    always_comb begin
        if (cmd.clear_wr) begin
            wr_row = '0;
        end else if (cmd.sweep_wr) begin
            wr_row = sweep_row;
        end else begin
            wr_row = eval_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_wr || cmd.sweep_wr) begin
            mem[idx_reg] <= wr_row;
        end else if (cmd.eval_commit) begin
            mem[bucket_reg] <= wr_row;
        end
        if (cmd.hash3) begin
            rd_row_reg <= mem[bucket];
        end else if (cmd.sweep_rd) begin
            rd_row_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            rr_reg      <= '0;
            rr_mod3_reg <= '0;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_wr || cmd.sweep_wr) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.eval_commit && eval_created && live_cnt != '0) begin
                rr_reg <= rr_reg + 32'd1;
                if (rr_reg == '1 || rr_mod3_reg == 2'd2) begin
                    rr_mod3_reg <= '0;
                end else begin
                    rr_mod3_reg <= rr_mod3_reg + 2'd1;
                end
            end
            if (cmd.finish_commit && op_reg == fpwb_pkg::OP_TICK) begin
                now_reg <= now_reg + 32'd1;
            end
            if (cmd.eval_commit || cmd.finish_commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval_commit) begin
            m_uplink_reg  <= eval_up;
            m_found_reg   <= hit;
            m_created_reg <= eval_created;
            m_full_reg    <= eval_full;
        end else if (cmd.finish_commit) begin
            m_uplink_reg  <= '0;
            m_found_reg   <= 1'b0;
            m_created_reg <= 1'b0;
            m_full_reg    <= 1'b0;
        end
    end

    assign sts.in_op    = fpwb_pkg::op_t'(s_operation);
    assign sts.idx_last = (idx_reg == '1);
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_uplink      = m_uplink_reg;
    assign m_found       = m_found_reg;
    assign m_created     = m_created_reg;
    assign m_bucket_full = m_full_reg;

endmodule

>>> hw/rtl/flow_pinned_wan_balancer.sv
// Top level of the flow-pinned WAN balancer: controller, datapath and checks.
// Depends on fpwb_pkg, fpwb_ctrl, fpwb_dp and flow_pinned_wan_balancer_defines.svh.
//
// One item is handled at a time and every item gives one result transfer. A packet
// lookup or an add-bytes item passes from its transfer to its result through two
// hash multiplier stages, a bucket read and the evaluate-and-write step of the
// single-ported flow table. A sweep walks all 1024 buckets, reading and then
// writing each one. After reset the table is cleared one bucket a cycle, so no
// input is taken until every bucket is cleared; configuration writes are accepted
// throughout.
`include "flow_pinned_wan_balancer_defines.svh"

module flow_pinned_wan_balancer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [31:0]                   s_first_ip,
    input  logic [31:0]                   s_second_ip,
    input  logic [7:0]                    s_proto_num,
    input  logic [31:0]                   s_byte_len,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fpwb_pkg::UPLINK_W-1:0] m_uplink,
    output logic                          m_found,
    output logic                          m_created,
    output logic                          m_bucket_full
);

    fpwb_pkg::cmd_t cmd;
    fpwb_pkg::sts_t sts;

    fpwb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fpwb_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_operation   (s_operation),
        .s_first_ip    (s_first_ip),
        .s_second_ip   (s_second_ip),
        .s_proto_num   (s_proto_num),
        .s_byte_len    (s_byte_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_uplink      (m_uplink),
        .m_found       (m_found),
        .m_created     (m_created),
        .m_bucket_full (m_bucket_full)
    );

    `FPWB_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while an item was in progress")
    `FPWB_ASSERT_NOW(a_flags_exclusive, aclk, aresetn, m_valid, !(m_created && (m_found || m_bucket_full)), "created flagged with found or full")
    `FPWB_ASSERT_NOW(a_full_gives_uplink0, aclk, aresetn, m_valid && m_bucket_full, m_uplink == '0, "full bucket result with nonzero uplink")

endmodule
